>>> rtl/blr_pkg.sv
// ----------------------------------------------------------------------------
// blr_pkg
// Shared types and constants for the Bresenham line raster block.
// ----------------------------------------------------------------------------
package blr_pkg;

  // Default coordinate width (signed)
  localparam int COORD_BITS_DEF = 12;
  // Frame size register width and colour width
  localparam int CFG_BITS   = 12;
  localparam int COLOR_BITS = 16;
  // Depth of the command queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;

  // Frame size after reset
  localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RST  = CFG_BITS'(188);
  localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RST = CFG_BITS'(120);

  // Command kinds carried on the input tuser
  typedef enum logic [0:0] {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_kind_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Frame clip window
  typedef struct packed {
    logic [CFG_BITS-1:0] width;
    logic [CFG_BITS-1:0] height;
  } frame_cfg_t;

endpackage

>>> rtl/blr_front.sv
// ----------------------------------------------------------------------------
// blr_front
// Input side: takes command words, works out the line set-up terms for a
// start (deltas, step directions) and hands a decoded word to the queue.
// ----------------------------------------------------------------------------
module blr_front #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF,
  parameter int IN_W       = ((4 * COORD_BITS + blr_pkg::COLOR_BITS + 7) / 8) * 8,
  parameter int ENTRY_W    = 6 * COORD_BITS + blr_pkg::COLOR_BITS + 5
) (
  input  logic               s_tvalid,
  output logic               s_tready,
  // tdata: start_x, start_y, end_x, end_y, pen_color (lowest bits first)
  input  logic [IN_W-1:0]    s_tdata,
  // tuser: command
  input  logic               s_tuser,
  input  logic               q_full,
  output logic               q_push,
  output logic [ENTRY_W-1:0] q_entry
);
  import blr_pkg::*;

  localparam int N = COORD_BITS;

  logic signed [N-1:0]      x0, y0, x1, y1;
  logic [COLOR_BITS-1:0]    color;
  logic signed [N:0]        dxs, dys;
  logic [N:0]               abs_dx;
  logic signed [N:0]        neg_abs_dy;
  logic                     step_right, step_down;
  cmd_kind_t                kind;

  // Field unpack
  assign x0    = s_tdata[N-1:0];
  assign y0    = s_tdata[2*N-1:N];
  assign x1    = s_tdata[3*N-1:2*N];
  assign y1    = s_tdata[4*N-1:3*N];
  assign color = s_tdata[4*N+COLOR_BITS-1:4*N];
  assign kind  = cmd_kind_t'(s_tuser);

  // Signed deltas, one bit wider than a coordinate
  assign dxs = {x1[N-1], x1} - {x0[N-1], x0};
  assign dys = {y1[N-1], y1} - {y0[N-1], y0};

  // Line set-up terms
  assign abs_dx     = dxs[N] ? (N+1)'(-dxs) : dxs;
  assign neg_abs_dy = dys[N] ? dys : -dys;
  assign step_right = !dxs[N] && (dxs != '0);
  assign step_down  = !dys[N] && (dys != '0);

  // Handshake: accept while the queue has room
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;
  assign q_entry  = {color, neg_abs_dy, abs_dx, step_down, step_right,
                     y1, x1, y0, x0, kind};

endmodule

>>> rtl/blr_cmd_fifo.sv
// ----------------------------------------------------------------------------
// blr_cmd_fifo
// Short register queue between the front and the back; first-word-fall-
// through read so the back sees the head word directly.
// ----------------------------------------------------------------------------
module blr_cmd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = blr_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);
  import blr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  // Occupancy
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slot[rd_ptr];

endmodule

>>> rtl/blr_back.sv
// ----------------------------------------------------------------------------
// blr_back
// Line engine: holds the Bresenham state, carries out start and step words
// from the queue and drives the pixel output register.
// ----------------------------------------------------------------------------
module blr_back #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF,
  parameter int OUT_W      = ((2 * COORD_BITS + blr_pkg::COLOR_BITS + 7) / 8) * 8,
  parameter int ENTRY_W    = 6 * COORD_BITS + blr_pkg::COLOR_BITS + 5
) (
  input  logic                clk,
  input  logic                rst,
  input  blr_pkg::frame_cfg_t frame,
  input  logic                q_valid,
  input  logic [ENTRY_W-1:0]  q_entry,
  output logic                q_pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  // tdata: pixel_x, pixel_y, pixel_color (lowest bits first)
  output logic [OUT_W-1:0]    m_tdata,
  // tuser: inside_res
  output logic                m_tuser,
  output logic                m_tlast
);
  import blr_pkg::*;

  localparam int N  = COORD_BITS;
  localparam int EW = N + 3;                                  // error accumulator
  localparam int CW = ((N > CFG_BITS) ? N : CFG_BITS) + 1;    // clip compare

  // Head word fields
  cmd_kind_t             h_kind;
  logic signed [N-1:0]   h_x0, h_y0, h_x1, h_y1;
  logic                  h_right, h_down;
  logic [N:0]            h_adx;
  logic signed [N:0]     h_ndy;
  logic [COLOR_BITS-1:0] h_color;

  // Line state
  logic signed [N-1:0]   cur_x, cur_y, goal_x, goal_y;
  logic [N:0]            abs_dx;
  logic signed [N:0]     neg_abs_dy;
  logic                  step_right, step_down;
  logic signed [EW-1:0]  err_acc;
  logic [COLOR_BITS-1:0] line_color;
  logic                  active;

  // Output register
  logic signed [N-1:0]   out_x, out_y;
  logic [COLOR_BITS-1:0] out_color;
  logic                  out_inside, out_last, out_valid;

  // Working terms
  logic signed [EW:0]    e2;
  logic                  move_x, move_y;
  logic signed [EW-1:0]  err_step, err_start;
  logic signed [N-1:0]   x_step, y_step;
  logic                  is_start, out_free, emit;
  logic signed [N-1:0]   nx, ny, ngx, ngy;
  logic                  fin, in_frame;

  assign {h_color, h_ndy, h_adx, h_down, h_right, h_y1, h_x1, h_y0, h_x0, h_kind} =
    q_entry;

  // Issue control: a word leaves the queue when the output slot is free
  assign out_free = !out_valid || m_tready;
  assign q_pop    = q_valid && out_free;
  assign is_start = (h_kind == CMD_START);
  assign emit     = q_pop && (is_start || active);

  // Error update for one step
  assign e2     = {err_acc, 1'b0};
  assign move_x = e2 >= $signed({{3{neg_abs_dy[N]}}, neg_abs_dy});
  assign move_y = e2 <= $signed({3'b000, abs_dx});
  assign err_step = err_acc
                  + (move_x ? $signed({{2{neg_abs_dy[N]}}, neg_abs_dy}) : '0)
                  + (move_y ? $signed({2'b00, abs_dx}) : '0);
  assign err_start = $signed({2'b00, h_adx}) + $signed({{2{h_ndy[N]}}, h_ndy});

  // Coordinate increments
  assign x_step = move_x ? (step_right ? cur_x + N'(1) : cur_x - N'(1)) : cur_x;
  assign y_step = move_y ? (step_down  ? cur_y + N'(1) : cur_y - N'(1)) : cur_y;

  // Pixel about to be emitted
  assign nx  = is_start ? h_x0 : x_step;
  assign ny  = is_start ? h_y0 : y_step;
  assign ngx = is_start ? h_x1 : goal_x;
  assign ngy = is_start ? h_y1 : goal_y;
  assign fin = (nx == ngx) && (ny == ngy);

  // Frame clip
  assign in_frame = !nx[N-1] && !ny[N-1]
                 && (CW'(unsigned'(nx)) < CW'(frame.width))
                 && (CW'(unsigned'(ny)) < CW'(frame.height));

  // Line state update
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x      <= '0;
      cur_y      <= '0;
      goal_x     <= '0;
      goal_y     <= '0;
      abs_dx     <= '0;
      neg_abs_dy <= '0;
      step_right <= 1'b0;
      step_down  <= 1'b0;
      err_acc    <= '0;
      line_color <= '0;
      active     <= 1'b0;
    end else if (emit) begin
      cur_x  <= nx;
      cur_y  <= ny;
      active <= !fin;
      if (is_start) begin
        goal_x     <= h_x1;
        goal_y     <= h_y1;
        abs_dx     <= h_adx;
        neg_abs_dy <= h_ndy;
        step_right <= h_right;
        step_down  <= h_down;
        err_acc    <= err_start;
        line_color <= h_color;
      end else begin
        err_acc <= err_step;
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_x      <= nx;
      out_y      <= ny;
      out_color  <= is_start ? h_color : line_color;
      out_inside <= in_frame;
      out_last   <= fin;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'({out_color, out_y, out_x});
  assign m_tuser  = out_inside;
  assign m_tlast  = out_last;

`ifndef NO_ASSERTIONS
  // A new pixel never overwrites one that is still waiting
  assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || m_tready))
    else $error("blr_back: output word overwritten");

  // The end point closes the line
  assert property (@(posedge clk) disable iff (rst)
    (emit && fin) |=> (!active && out_last && out_valid))
    else $error("blr_back: line still active after end point");

  // A step with no line in progress leaves the position alone
  assert property (@(posedge clk) disable iff (rst)
    (q_pop && !is_start && !active) |=> ($stable(cur_x) && $stable(cur_y) && !active))
    else $error("blr_back: idle step moved the pen");

  // Each step moves the pen on at least one axis
  assert property (@(posedge clk) disable iff (rst)
    (emit && !is_start) |-> (move_x || move_y))
    else $error("blr_back: step without movement");
`endif

endmodule

>>> rtl/bresenham_line_raster.sv
// ----------------------------------------------------------------------------
// bresenham_line_raster
// All-octant Bresenham line generator with a per-pixel frame clip.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake           | payload
//  ----------+-----+---------------------+----------------------------------
//  s_*       | in  | s_tvalid / s_tready | tdata endpoints+colour, tuser cmd
//  m_*       | out | m_tvalid / m_tready | tdata pixel+colour, tuser inside,
//            |     |                     | tlast end point
//  cfg_*     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data (frame size)
//
//  One command word per cycle sustained while m_tready stays high; a word
//  passes the queue register, then the output register, before its pixel
//  is valid on m_*.
//  Each step is up to two error adds and a one-unit move on x, y or both.
//  Reset (rst, synchronous) sets the frame to 188 x 120 and leaves no line.
//  A stalled output fills the two-word queue, after which s_tready drops.
// ----------------------------------------------------------------------------
module bresenham_line_raster #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF,
  parameter int IN_W       = ((4 * COORD_BITS + blr_pkg::COLOR_BITS + 7) / 8) * 8,
  parameter int OUT_W      = ((2 * COORD_BITS + blr_pkg::COLOR_BITS + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // tdata: start_x, start_y, end_x, end_y, pen_color (lowest bits first)
  input  logic [IN_W-1:0]              s_tdata,
  // tuser: command
  input  logic                         s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // tdata: pixel_x, pixel_y, pixel_color (lowest bits first)
  output logic [OUT_W-1:0]             m_tdata,
  // tuser: inside_res
  output logic                         m_tuser,
  output logic                         m_tlast,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [blr_pkg::CFG_BITS-1:0] cfg_data
);
  import blr_pkg::*;

  localparam int ENTRY_W = 6 * COORD_BITS + COLOR_BITS + 5;

  frame_cfg_t         frame;
  logic               q_full, q_push, q_pop, q_valid;
  logic [ENTRY_W-1:0] q_in, q_head;

  // Frame size registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame.width  <= FRAME_WIDTH_RST;
      frame.height <= FRAME_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame.width  <= cfg_data;
        REG_FRAME_HEIGHT: frame.height <= cfg_data;
        default:          frame        <= frame;
      endcase
    end
  end

  blr_front #(
    .COORD_BITS (COORD_BITS),
    .IN_W       (IN_W),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  blr_cmd_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  blr_back #(
    .COORD_BITS (COORD_BITS),
    .OUT_W      (OUT_W),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .frame    (frame),
    .q_valid  (q_valid),
    .q_entry  (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> tb/tb_bresenham_line_raster.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bresenham_line_raster
// Self-checking bench for the all-octant Bresenham line raster. A directed
// table covers the endpoint extremes, single-point lines, abandoned lines and
// steps with no line in progress. Random lines then run under several frame
// sizes and flow-control patterns. Every accepted command word goes through
// a local line-stepping predictor, and each pixel word that leaves the block
// is compared field by field with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module tb_bresenham_line_raster;
  import blr_pkg::*;

  localparam int CB         = COORD_BITS_DEF;
  localparam int IN_W       = ((4 * CB + COLOR_BITS + 7) / 8) * 8;
  localparam int OUT_W      = ((2 * CB + COLOR_BITS + 7) / 8) * 8;
  localparam int QUIET_MAX  = 2000;  // cycles with no word moving anywhere
  localparam int HOLD_LEN   = 200;   // long output hold-off
  localparam int SETTLE     = 8;     // queue plus output register, with margin
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic signed [CB-1:0]   x;
    logic signed [CB-1:0]   y;
    logic [COLOR_BITS-1:0]  color;
    logic                   in_frame;
    logic                   fin;
  } pixel_t;

  // Where a directed row takes its expected pixel from
  typedef enum int {WANT_PRED, WANT_TYPED, WANT_NONE} want_src_t;

  typedef struct {
    cmd_kind_t   kind;
    int          sx, sy, ex, ey;
    logic [15:0] color;
    want_src_t   src;
    int          wx, wy;
    logic        win, wlast;
  } plan_row_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [OUT_W-1:0]    m_tdata;
  logic                m_tuser;
  logic                m_tlast;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  // Line predictor state, at the block's widths but ln_ndy, one bit wider
  logic [CFG_BITS-1:0]   fw, fh;
  logic signed [CB-1:0]  cur_x, cur_y, goal_x, goal_y;
  logic signed [CB:0]    ln_dx;
  logic signed [CB+1:0]  ln_ndy;
  logic signed [CB+2:0]  ln_err;
  logic                  ln_right, ln_down, ln_busy;
  logic [COLOR_BITS-1:0] ln_color;

  pixel_t    pending_pixels[$];
  plan_row_t plan[$];
  int        mismatches;
  int        snd_idle, rcv_idle;
  int        quiet;
  int        hold_left;
  bit        hold_req;

  bresenham_line_raster uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor: advance the line for one command word, return 1 with a pixel
  function automatic bit raster_step(input cmd_kind_t kind, input logic [IN_W-1:0] w,
                                     output pixel_t px);
    logic signed [CB-1:0] x0, y0, x1, y1;
    int dx, dy, e2;
    px = '0;
    if (kind == CMD_START) begin
      x0 = w[CB-1:0];
      y0 = w[2*CB-1:CB];
      x1 = w[3*CB-1:2*CB];
      y1 = w[4*CB-1:3*CB];
      dx = int'(x1) - int'(x0);
      dy = int'(y1) - int'(y0);
      ln_dx    = (CB+1)'((dx >= 0) ? dx : -dx);
      ln_ndy   = (CB+2)'((dy >= 0) ? -dy : dy);
      ln_right = x0 < x1;
      ln_down  = y0 < y1;
      ln_err   = (CB+3)'(int'(ln_dx) + int'(ln_ndy));
      cur_x    = x0;
      cur_y    = y0;
      goal_x   = x1;
      goal_y   = y1;
      ln_color = w[4*CB+COLOR_BITS-1:4*CB];
    end else begin
      if (!ln_busy) return 1'b0;
      e2 = 2 * int'(ln_err);
      if (e2 >= int'(ln_ndy)) begin
        ln_err = (CB+3)'(int'(ln_err) + int'(ln_ndy));
        cur_x  = CB'(int'(cur_x) + (ln_right ? 1 : -1));
      end
      if (e2 <= int'(ln_dx)) begin
        ln_err = (CB+3)'(int'(ln_err) + int'(ln_dx));
        cur_y  = CB'(int'(cur_y) + (ln_down ? 1 : -1));
      end
    end
    px.x        = cur_x;
    px.y        = cur_y;
    px.color    = ln_color;
    px.in_frame = (int'(cur_x) >= 0) && (int'(cur_y) >= 0) &&
                  (int'(cur_x) < int'(fw)) && (int'(cur_y) < int'(fh));
    px.fin      = (cur_x == goal_x) && (cur_y == goal_y);
    ln_busy     = !px.fin;
    return 1'b1;
  endfunction

  function automatic logic [IN_W-1:0] pack_cmd(input int sx, sy, ex, ey,
                                               input logic [15:0] col);
    return {col, 12'(ey), 12'(ex), 12'(sy), 12'(sx)};
  endfunction

  function automatic int clamp_coord(input int v);
    return (v < -2048) ? -2048 : (v > 2047) ? 2047 : v;
  endfunction

  function automatic int iabs(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void add_row(input cmd_kind_t kind, input int sx, sy, ex, ey,
                                  input logic [15:0] col, input want_src_t src,
                                  input int wx, wy, input logic win, wlast);
    plan_row_t r;
    r.kind = kind; r.sx = sx; r.sy = sy; r.ex = ex; r.ey = ey; r.color = col;
    r.src = src; r.wx = wx; r.wy = wy; r.win = win; r.wlast = wlast;
    plan.push_back(r);
  endfunction

  // Offer one command word; on acceptance run the predictor
  task automatic put_word(input cmd_kind_t kind, input logic [IN_W-1:0] w,
                          output bit got, output pixel_t px);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    got = raster_step(kind, w, px);
  endtask

  task automatic issue(input cmd_kind_t kind, input logic [IN_W-1:0] w);
    bit got;
    pixel_t px;
    put_word(kind, w, got, px);
    if (got) pending_pixels.push_back(px);
  endtask

  // Stop offering, wait for every predicted pixel, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write both frame registers back to back
  task automatic set_frame(input int w, h);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= CFG_BITS'(w);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    fw = CFG_BITS'(w);
    @(negedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= CFG_BITS'(h);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    fh = CFG_BITS'(h);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random line: start word, then steps; counts words that move the line
  task automatic random_line(output int used);
    int x0, y0, x1, y1, len, n, r;
    logic [15:0] col;
    r   = $urandom_range(99);
    col = 16'($urandom);
    if (r < 70) begin
      // short lines around the frame
      x0 = int'($urandom_range(260)) - 40;
      y0 = int'($urandom_range(180)) - 30;
      x1 = x0 + int'($urandom_range(24)) - 12;
      y1 = y0 + int'($urandom_range(24)) - 12;
    end else if (r < 88) begin
      // short lines anywhere, pinned to the coordinate range
      x0 = int'($urandom_range(4095)) - 2048;
      y0 = int'($urandom_range(4095)) - 2048;
      x1 = clamp_coord(x0 + int'($urandom_range(40)) - 20);
      y1 = clamp_coord(y0 + int'($urandom_range(40)) - 20);
    end else begin
      // long lines, normally abandoned early
      x0 = int'($urandom_range(4095)) - 2048;
      y0 = int'($urandom_range(4095)) - 2048;
      x1 = int'($urandom_range(4095)) - 2048;
      y1 = int'($urandom_range(4095)) - 2048;
    end
    len = (iabs(x1 - x0) > iabs(y1 - y0)) ? iabs(x1 - x0) : iabs(y1 - y0);
    if (r >= 88)                    n = $urandom_range(12);
    else if ($urandom_range(9) == 0) n = $urandom_range(len);
    else                            n = len + $urandom_range(2);
    used = 1;
    // occasional stray step ahead of the start
    if ($urandom_range(19) == 0) issue(CMD_STEP, {$urandom, $urandom});
    issue(CMD_START, pack_cmd(x0, y0, x1, y1, col));
    for (int i = 0; i < n; i++) begin
      issue(CMD_STEP, {$urandom, $urandom});
      if (i < len) used++;
    end
  endtask

  // Output side: ready pattern plus the long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // Pixel checker
  always @(posedge clk) begin
    pixel_t want, seen;
    if (!rst && m_tvalid && m_tready) begin
      seen.x        = m_tdata[CB-1:0];
      seen.y        = m_tdata[2*CB-1:CB];
      seen.color    = m_tdata[2*CB+COLOR_BITS-1:2*CB];
      seen.in_frame = m_tuser;
      seen.fin      = m_tlast;
      if (pending_pixels.size() == 0) begin
        $error("pixel word with none predicted: x %0d y %0d", seen.x, seen.y);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (seen.x != want.x) begin
          $error("pixel_x: expected %0d, got %0d", want.x, seen.x);
          mismatches++;
        end
        if (seen.y != want.y) begin
          $error("pixel_y: expected %0d, got %0d", want.y, seen.y);
          mismatches++;
        end
        if (seen.color != want.color) begin
          $error("pixel_color: expected %h, got %h", want.color, seen.color);
          mismatches++;
        end
        if (seen.in_frame != want.in_frame) begin
          $error("inside_res: expected %0b, got %0b", want.in_frame, seen.in_frame);
          mismatches++;
        end
        if (seen.fin != want.fin) begin
          $error("last: expected %0b, got %0b", want.fin, seen.fin);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles in which no word moves
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Stimulus
  initial begin
    int fr_w[8], fr_h[8];
    int done, lines, used;
    bit got;
    pixel_t px, typed;
    plan_row_t r;

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = CMD_START;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data  = '0;
    mismatches = 0;
    quiet      = 0;
    hold_left  = 0;
    hold_req   = 1'b0;
    snd_idle   = 32;
    rcv_idle   = 67;
    fw = FRAME_WIDTH_RST;
    fh = FRAME_HEIGHT_RST;
    {cur_x, cur_y, goal_x, goal_y, ln_dx, ln_ndy, ln_err} = '0;
    {ln_right, ln_down, ln_busy} = '0;
    ln_color = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows, frame at its reset size of 188 x 120
    add_row(CMD_STEP,  0, 0, 0, 0, 16'h0000, WANT_NONE, 0, 0, 0, 0);
    add_row(CMD_START, 0, 0, 0, 0, 16'hFFFF, WANT_TYPED, 0, 0, 1, 1);
    add_row(CMD_STEP,  0, 0, 0, 0, 16'h0000, WANT_NONE, 0, 0, 0, 0);
    add_row(CMD_START, -2048, -2048, 2047, 2047, 16'h0000, WANT_TYPED, -2048, -2048, 0, 0);
    add_row(CMD_STEP,  0, 0, 0, 0, 16'h0000, WANT_PRED, 0, 0, 0, 0);
    add_row(CMD_START, 2047, 2047, -2048, -2048, 16'hA5A5, WANT_TYPED, 2047, 2047, 0, 0);
    add_row(CMD_STEP,  0, 0, 0, 0, 16'h0000, WANT_PRED, 0, 0, 0, 0);
    add_row(CMD_START, 2047, -2048, -2048, 2047, 16'h0F0F, WANT_TYPED, 2047, -2048, 0, 0);
    add_row(CMD_STEP,  0, 0, 0, 0, 16'h0000, WANT_PRED, 0, 0, 0, 0);
    add_row(CMD_START, 187, 119, 188, 120, 16'h5A5A, WANT_TYPED, 187, 119, 1, 0);
    add_row(CMD_STEP,  0, 0, 0, 0, 16'h0000, WANT_PRED, 0, 0, 0, 0);
    add_row(CMD_START, 10, 10, 12, 11, 16'h1111, WANT_PRED, 0, 0, 0, 0);
    add_row(CMD_STEP,  0, 0, 0, 0, 16'h0000, WANT_PRED, 0, 0, 0, 0);
    add_row(CMD_STEP,  0, 0, 0, 0, 16'h0000, WANT_PRED, 0, 0, 0, 0);
    add_row(CMD_START, 10, 10, 9, 12, 16'h2222, WANT_PRED, 0, 0, 0, 0);
    add_row(CMD_STEP,  0, 0, 0, 0, 16'h0000, WANT_PRED, 0, 0, 0, 0);
    add_row(CMD_STEP,  0, 0, 0, 0, 16'h0000, WANT_PRED, 0, 0, 0, 0);
    add_row(CMD_START, 0, 0, -2, -1, 16'h3333, WANT_PRED, 0, 0, 0, 0);
    add_row(CMD_STEP,  0, 0, 0, 0, 16'h0000, WANT_PRED, 0, 0, 0, 0);
    add_row(CMD_STEP,  0, 0, 0, 0, 16'h0000, WANT_PRED, 0, 0, 0, 0);
    add_row(CMD_START, -1, 5, 1, 3, 16'h4444, WANT_PRED, 0, 0, 0, 0);
    add_row(CMD_STEP,  0, 0, 0, 0, 16'h0000, WANT_PRED, 0, 0, 0, 0);
    add_row(CMD_STEP,  0, 0, 0, 0, 16'h0000, WANT_PRED, 0, 0, 0, 0);
    add_row(CMD_STEP,  0, 0, 0, 0, 16'h0000, WANT_NONE, 0, 0, 0, 0);

    foreach (plan[i]) begin
      r = plan[i];
      put_word(r.kind, pack_cmd(r.sx, r.sy, r.ex, r.ey, r.color), got, px);
      if (r.src == WANT_TYPED) begin
        typed.x = 12'(r.wx); typed.y = 12'(r.wy); typed.color = r.color;
        typed.in_frame = r.win; typed.fin = r.wlast;
        pending_pixels.push_back(typed);
      end else if (r.src == WANT_PRED && got) begin
        pending_pixels.push_back(px);
      end
    end
    drain();

    // Random phases: frame size extremes, zero frame, random sizes
    fr_w = '{2048, 1, 0, $urandom_range(1, 2048), 2048, 1, 188, $urandom_range(1, 2048)};
    fr_h = '{2048, 1, 0, $urandom_range(1, 2048), 1, 2048, 120, $urandom_range(1, 2048)};
    for (int ph = 0; ph < 8; ph++) begin
      snd_idle = (ph < 3) ? 32 : (ph < 6) ? 67 : 0;
      rcv_idle = (ph < 3) ? 67 : (ph < 6) ? 32 : 0;
      set_frame(fr_w[ph], fr_h[ph]);
      done  = 0;
      lines = 0;
      while (done < PHASE_ITEMS) begin
        if (ph == 1 && lines == 3) hold_req = 1'b1;
        if (ph == 4 && lines == 6) drain();
        random_line(used);
        done += used;
        lines++;
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
